[design/ils_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int unsigned KindW   = 3;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenW    = 9;

  typedef enum logic [KindW-1:0] {
    KIND_READ       = 3'd0,
    KIND_INS_FRONT  = 3'd1,
    KIND_INS_BACK   = 3'd2,
    KIND_INS_POS    = 3'd3,
    KIND_DELETE     = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_READ,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_READ
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;      // capture request
    logic    decide;    // evaluate request
    logic    shift;     // move one entry, advance pointer
    logic    finish;    // write insert value / update length
    logic    rd_issue;  // start memory read
    logic    out_load;  // latch result
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic shift_done;
  } stat_t;

endpackage

[design/ils_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_req_if / ils_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ils_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [15:0] position;
  logic signed [31:0] value;
  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ils_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  logic               found;
  logic [1:0]         status;
  logic [8:0]         length;
  modport source (output valid, read_value, found, status, length, input ready);
  modport sink   (input valid, read_value, found, status, length, output ready);
endinterface

[design/ils_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_ctrl
// Sequencer for request capture, entry shifting and result hand-off.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctrl_o.decide = 1'b1;
        state_d       = S_SHIFT;
      end
      S_SHIFT: begin
        unique case (stat_i.op)
          OP_READ: begin
            ctrl_o.rd_issue = 1'b1;
            state_d         = S_READ;
          end
          OP_NONE: begin
            ctrl_o.out_load = 1'b1;
            state_d         = S_OUT;
          end
          default: begin
            if (stat_i.shift_done) begin
              ctrl_o.finish   = 1'b1;
              ctrl_o.out_load = 1'b1;
              state_d         = S_OUT;
            end else begin
              ctrl_o.shift = 1'b1;
            end
          end
        endcase
      end
      S_READ: begin
        ctrl_o.out_load = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[design/ils_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ils_dp
// Entry memory, length register, shift pointer and result registers.
// ----------------------------------------------------------------------------
module ils_dp
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  input  logic [2:0]         kind_i,
  input  logic signed [15:0] position_i,
  input  logic signed [31:0] value_i,
  output logic signed [31:0] read_value_o,
  output logic               found_o,
  output logic [1:0]         status_o,
  output logic [8:0]         length_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [31:0]        mem [CAPACITY];
  logic [31:0]        rd_q;
  logic [CW-1:0]      len_q;
  logic [2:0]         kind_q;
  logic signed [15:0] pos_q;
  logic [31:0]        val_q;
  op_e                op_q;
  status_e            st_q;
  logic [CW-1:0]      tgt_q;
  logic [CW-1:0]      ptr_q;
  logic signed [31:0] rv_q;
  logic               found_q;
  logic [1:0]         status_q;

  logic          pos_neg;
  logic [CW:0]   pos_u;
  logic          pos_in;
  logic [CW:0]   ins_pos;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [31:0]   mem_wd;
  logic [AW-1:0] mem_ra;
  logic [AW-1:0] rd_addr;
  op_e           op_d_w;
  logic [CW-1:0] ptr_d_w;
  status_e       st_d_w;

  assign pos_neg = pos_q[15];
  assign pos_u   = (CW + 1 > 16) ? (CW + 1)'($unsigned(pos_q)) : pos_q[CW:0];
  assign pos_in  = !pos_neg && ((16 > CW + 1) ? (pos_q[15:0] < 16'(len_q))
                                                : (pos_u < {1'b0, len_q}));

  always_comb begin
    ins_pos = '0;
    unique case (kind_q)
      KIND_INS_BACK: ins_pos = {1'b0, len_q};
      KIND_INS_POS:  ins_pos = pos_neg ? '0
                             : ((16 > CW + 1) && (pos_q[15:0] > 16'(len_q)))
                               ? {1'b1, {CW{1'b0}}} : pos_u;
      default:       ins_pos = '0;
    endcase
  end

  // insert: ptr walks len -> tgt copying mem[ptr-1] to mem[ptr]
  // delete: ptr walks tgt -> len-1 copying mem[ptr+1] to mem[ptr]
  assign stat_o.op         = op_q;
  assign stat_o.shift_done = (op_q == OP_INSERT) ? (ptr_q == tgt_q)
                                                 : (ptr_q + CW'(1) >= len_q);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q[AW-1:0];
    mem_wd = rd_q;
    mem_ra = ptr_q[AW-1:0];
    if (ctrl_i.decide || ctrl_i.shift) begin
      mem_ra = (op_q == OP_INSERT) ? AW'(ptr_q - CW'(1)) : AW'(ptr_q + CW'(1));
    end
    if (ctrl_i.rd_issue) begin
      mem_ra = pos_q[AW-1:0];
    end
    if (ctrl_i.shift) begin
      mem_we = 1'b1;
    end
    if (ctrl_i.finish && op_q == OP_INSERT) begin
      mem_we = 1'b1;
      mem_wd = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // read port: address differs in decide, so use next pointer view
  always_comb begin
    rd_addr = mem_ra;
    if (ctrl_i.decide) begin
      rd_addr = (op_d_w == OP_INSERT) ? AW'({1'b0, len_q} - 1'b1) : AW'(ptr_d_w + CW'(1));
    end else if (ctrl_i.shift) begin
      rd_addr = (op_q == OP_INSERT) ? AW'(ptr_q - CW'(2)) : AW'(ptr_q + CW'(2));
    end
  end

  always_comb begin
    op_d_w  = OP_NONE;
    st_d_w  = ST_RANGE;
    ptr_d_w = '0;
    unique case (kind_q)
      KIND_READ: begin
        if (pos_in) begin
          op_d_w = OP_READ;
          st_d_w = ST_DONE;
        end
      end
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        if (ins_pos > {1'b0, len_q}) begin
          st_d_w = ST_RANGE;
        end else if ({1'b0, len_q} >= (CW + 1)'(CAPACITY)) begin
          st_d_w = ST_FULL;
        end else begin
          op_d_w  = OP_INSERT;
          st_d_w  = ST_DONE;
          ptr_d_w = len_q;
        end
      end
      KIND_DELETE: begin
        if (pos_in) begin
          op_d_w  = OP_DELETE;
          st_d_w  = ST_DONE;
          ptr_d_w = pos_u[CW-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (ctrl_i.load) begin
      kind_q <= kind_i;
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (ctrl_i.decide) begin
      op_q  <= op_d_w;
      st_q  <= st_d_w;
      ptr_q <= ptr_d_w;
      tgt_q <= ins_pos[CW-1:0];
    end
    if (ctrl_i.shift) begin
      ptr_q <= (op_q == OP_INSERT) ? ptr_q - CW'(1) : ptr_q + CW'(1);
    end
    if (ctrl_i.out_load) begin
      status_q <= st_q;
      found_q  <= (op_q == OP_READ);
      rv_q     <= (op_q == OP_READ) ? rd_q
                : (kind_q == KIND_READ) ? -32'sd1 : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (ctrl_i.finish) begin
      len_q <= (op_q == OP_INSERT) ? len_q + CW'(1) : len_q - CW'(1);
    end
  end

  assign read_value_o = rv_q;
  assign found_o      = found_q;
  assign status_o     = status_q;
  assign length_o     = (CW >= 9) ? len_q[8:0] : 9'(len_q);

endmodule

[design/indexed_list_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of signed 32-bit values with positional read, insert, delete.
// ----------------------------------------------------------------------------
// One request at a time. From acceptance, every request passes the decide and
// shift states; a read then passes the read state, and an insert or delete
// stays in the shift state while it moves entries (up to CAPACITY - 1), the
// entry memory moving one entry per cycle. The input is ready again in the
// cycle after the result transaction. No clearing pass is needed after reset.
module indexed_list_store_unit
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  ils_req_if.sink   req,
  ils_rsp_if.source rsp
);

  ctrl_t ctrl;
  stat_t stat;

  ils_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ils_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .kind_i       (req.kind),
    .position_i   (req.position),
    .value_i      (req.value),
    .read_value_o (rsp.read_value),
    .found_o      (rsp.found),
    .status_o     (rsp.status),
    .length_o     (rsp.length)
  );

endmodule

[dv/tb_indexed_list_store_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_store_unit
// Request/result test of the indexed list store: every request kind, reads
// and deletes inside and outside the list, negative and past-end insert
// positions, full-list drops and undefined kinds. Results are predicted by a
// list model kept in the testbench and checked in order.
// ----------------------------------------------------------------------------
module tb_indexed_list_store_unit;
  import ils_pkg::*;

  localparam int unsigned Capacity = 256;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic                   found;
    logic [StatusW-1:0]     status;
    logic [LenW-1:0]        length;
  } result_t;

  logic clk_i;
  logic rst_ni;

  ils_req_if req ();
  ils_rsp_if rsp ();

  indexed_list_store_unit #(.CAPACITY(Capacity)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  logic signed [ValW-1:0] list_q[$];
  result_t                pending_q[$];
  int                     n_err;
  int                     n_sent;
  int                     n_checked;
  int                     hold_cycles;
  bit                     burst_mode;

  initial begin
    clk_i = 1'b0;
  end
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic result_t predict_list(logic [KindW-1:0] kind,
                                           logic signed [PosW-1:0] pos,
                                           logic signed [ValW-1:0] val);
    result_t r;
    int      p;
    int      n;
    r = '0;
    p = pos;
    n = list_q.size();
    case (kind)
      KIND_READ: begin
        if (p >= 0 && p < n) begin
          r.read_value = list_q[p];
          r.found      = 1'b1;
        end else begin
          r.read_value = -1;
          r.status     = ST_RANGE;
        end
      end
      KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
        if (kind == KIND_INS_FRONT) p = 0;
        else if (kind == KIND_INS_BACK) p = n;
        else if (p < 0) p = 0;
        if (p > n) r.status = ST_RANGE;
        else if (n >= Capacity) r.status = ST_FULL;
        else list_q.insert(p, val);
      end
      KIND_DELETE: begin
        if (p >= 0 && p < n) list_q.delete(p);
        else r.status = ST_RANGE;
      end
      default: r.status = ST_RANGE;
    endcase
    r.length = LenW'(list_q.size());
    return r;
  endfunction

  task automatic send_req(logic [KindW-1:0] kind, logic signed [PosW-1:0] pos,
                          logic signed [ValW-1:0] val);
    int gap;
    if (!burst_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid    <= 1'b1;
    req.kind     <= kind;
    req.position <= pos;
    req.value    <= val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    pending_q.push_back(predict_list(kind, pos, val));
    n_sent++;
  endtask

  function automatic logic signed [ValW-1:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [PosW-1:0] rand_pos();
    int n;
    n = list_q.size();
    case ($urandom_range(0, 9))
      0: return PosW'($urandom);
      1: return PosW'(-$urandom_range(1, 3));
      2: return PosW'(n + $urandom_range(0, 2));
      default: return (n == 0) ? '0 : PosW'($urandom_range(0, n - 1));
    endcase
  endfunction

  // result receiver: random stall pattern, plus long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      rsp.ready   <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp.ready <= ($urandom_range(0, 7) > 2);
    end
  end

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transaction");
        n_err++;
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        if (rsp.read_value !== e.read_value) begin
          $error("read_value exp %0d act %0d", e.read_value, rsp.read_value);
          n_err++;
        end
        if (rsp.found !== e.found) begin
          $error("found exp %0d act %0d", e.found, rsp.found);
          n_err++;
        end
        if (rsp.status !== e.status) begin
          $error("status exp %0d act %0d", e.status, rsp.status);
          n_err++;
        end
        if (rsp.length !== e.length) begin
          $error("length exp %0d act %0d", e.length, rsp.length);
          n_err++;
        end
      end
    end
  end

  task automatic test_directed();
    send_req(KIND_READ, 0, 0);
    send_req(KIND_DELETE, 0, 0);
    send_req(KIND_INS_POS, 1, 5);
    send_req(KIND_INS_POS, -32768, 32'h7fff_ffff);
    send_req(KIND_INS_FRONT, 0, 32'h8000_0000);
    send_req(KIND_INS_BACK, 32767, -1);
    send_req(KIND_INS_POS, 3, 0);
    send_req(KIND_INS_POS, 1, 32'h5555_aaaa);
    send_req(KIND_READ, 0, 0);
    send_req(KIND_READ, 4, 0);
    send_req(KIND_READ, 5, 0);
    send_req(KIND_READ, -1, 0);
    send_req(KIND_READ, 32767, 0);
    send_req(KIND_READ, -32768, 0);
    send_req(3'd5, 0, 1);
    send_req(3'd6, 16'h5555, 2);
    send_req(3'd7, 16'haaaa, 3);
    send_req(KIND_DELETE, -1, 0);
    send_req(KIND_DELETE, 4, 0);
    send_req(KIND_DELETE, 4, 0);
    send_req(KIND_DELETE, 0, 0);
    send_req(KIND_READ, 2, 0);
  endtask

  task automatic test_fill_full();
    while (list_q.size() < Capacity) send_req(KIND_INS_BACK, 0, $urandom);
    send_req(KIND_INS_FRONT, 0, 1);
    send_req(KIND_INS_BACK, 0, 2);
    send_req(KIND_INS_POS, PosW'(Capacity), 3);
    send_req(KIND_INS_POS, PosW'(Capacity + 1), 4);
    send_req(KIND_READ, PosW'(Capacity - 1), 0);
    send_req(KIND_READ, PosW'(Capacity), 0);
    send_req(KIND_DELETE, PosW'(Capacity - 1), 0);
    send_req(KIND_DELETE, 0, 0);
    while (list_q.size() > 4) send_req(KIND_DELETE, 0, 0);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    burst_mode  = 1'b1;
    repeat (12) send_req(KIND_INS_FRONT, 0, $urandom);
    burst_mode = 1'b0;
  endtask

  task automatic test_random(int count);
    int k;
    int burst;
    repeat (count) begin
      if (burst == 0) begin
        burst      = $urandom_range(1, 20);
        burst_mode = $urandom_range(0, 2) != 0;
      end
      burst--;
      k = $urandom_range(0, 99);
      if (k < 4) send_req(KindW'($urandom_range(5, 7)), PosW'($urandom), $urandom);
      else if (k < 28) send_req(KIND_READ, rand_pos(), $urandom);
      else if (k < 40) send_req(KIND_INS_FRONT, PosW'($urandom), rand_val());
      else if (k < 52) send_req(KIND_INS_BACK, PosW'($urandom), rand_val());
      else if (k < 72) send_req(KIND_INS_POS, rand_pos(), rand_val());
      else send_req(KIND_DELETE, rand_pos(), $urandom);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    int drain;
    n_err       = 0;
    n_sent      = 0;
    n_checked   = 0;
    hold_cycles = 0;
    burst_mode  = 1'b0;
    rst_ni      = 1'b0;
    req.valid    = 1'b0;
    req.kind     = '0;
    req.position = '0;
    req.value    = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_fill_full();
    test_random(900);
    req.valid <= 1'b0;
    drain = 0;
    while (pending_q.size() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (Capacity + 20) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      n_err++;
    end
    $display("Sent %0d requests, checked %0d results: all kinds, range misses,",
             n_sent, n_checked);
    $display("full-list drops, undefined kinds and a long result stall.");
    if (n_err == 0) begin
      $display("PASS indexed_list_store_unit");
    end else begin
      $display("FAIL indexed_list_store_unit");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAIL indexed_list_store_unit");
    $finish;
  end

endmodule

[files.f]
design/ils_pkg.sv
design/ils_if.sv
design/ils_ctrl.sv
design/ils_dp.sv
design/indexed_list_store_unit.sv
dv/tb_indexed_list_store_unit.sv
